@@ hw/rtl/ple_pkg.sv @@
package ple_pkg;

  // default sizes
  localparam int unsigned DEPTH_DEF      = 64;
  localparam int unsigned VALUE_BITS_DEF = 16;

  // item field widths
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEN_W    = 7;

  localparam int unsigned IN_FIELDS_W  = ACTION_W + POS_W + VAL_W;
  localparam int unsigned OUT_FIELDS_W = VAL_W + STATUS_W + LEN_W;
  localparam int unsigned IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INS_HEAD = 3'd0,
    ACT_INS_TAIL = 3'd1,
    ACT_INS_POS  = 3'd2,
    ACT_REM_HEAD = 3'd3,
    ACT_REM_TAIL = 3'd4,
    ACT_REM_POS  = 3'd5
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_FULL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_FINISH
  } state_e;

endpackage

@@ hw/rtl/positional_list_engine.sv @@
// channel  | direction | fields (tdata, lowest bit first)
// s_axis   | in        | action[2:0], position[9:3], value[25:10], zeros above
// m_axis   | out       | removed_value[15:0], status[17:16], length[24:18], zeros above
//
// one request at a time; a shift moves one entry per cycle through the two-port list
// memory (one read, one write a cycle); an accepted request passes through ST_SHIFT, where
// the entries move, then ST_FINISH; a tail insert moves no entries, and a request that
// fails or is unused goes from ST_IDLE straight to ST_FINISH
// no clearing pass: reset only empties the length, the memory is never read past it
// a result waits in the output register while the next request is taken
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // action, position, value
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // removed_value, status, length
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned VB   = VALUE_BITS;

  state_e              state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic                is_ins_q, is_ins_d;
  logic                take_q, take_d;
  logic                upd_q, upd_d;
  logic                rd_pend_q, rd_pend_d;
  logic [AW-1:0]       ptr_q, ptr_d;
  logic [CW-1:0]       left_q, left_d;
  logic [AW-1:0]       rd_addr_q, rd_addr_d;
  logic [AW-1:0]       at_q, at_d;
  logic [VB-1:0]       val_q, val_d;
  logic [VB-1:0]       removed_q, removed_d;
  status_e             status_q, status_d;

  logic                out_valid_q, out_valid_d;
  logic [VAL_W-1:0]    out_removed_q, out_removed_d;
  status_e             out_status_q, out_status_d;
  logic [LEN_W-1:0]    out_len_q, out_len_d;

  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_wa, mem_ra;
  logic [VB-1:0]       mem_wd;
  logic [VB-1:0]       rd_data_q;
  logic [VB-1:0]       mem_q [DEPTH];

  logic [ACTION_W-1:0] in_action;
  logic [POS_W-1:0]    in_pos;
  logic [VAL_W-1:0]    in_value;
  logic [CMPW-1:0]     pos_ext, cnt_ext, at_sel;
  logic [CW-1:0]       count_next;

  assign in_action = s_axis_tdata[ACTION_W-1:0];
  assign in_pos    = s_axis_tdata[ACTION_W+POS_W-1:ACTION_W];
  assign in_value  = s_axis_tdata[IN_FIELDS_W-1:ACTION_W+POS_W];
  assign pos_ext   = CMPW'(in_pos);
  assign cnt_ext   = CMPW'(count_q);

  assign count_next = !upd_q    ? count_q :
                      is_ins_q  ? count_q + CW'(1) : count_q - CW'(1);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_len_q, out_status_q, out_removed_q};

  // list memory, read data registered
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      is_ins_q    <= 1'b0;
      take_q      <= 1'b0;
      upd_q       <= 1'b0;
      rd_pend_q   <= 1'b0;
      ptr_q       <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      is_ins_q    <= is_ins_d;
      take_q      <= take_d;
      upd_q       <= upd_d;
      rd_pend_q   <= rd_pend_d;
      ptr_q       <= ptr_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q     <= rd_addr_d;
    at_q          <= at_d;
    val_q         <= val_d;
    removed_q     <= removed_d;
    status_q      <= status_d;
    out_removed_q <= out_removed_d;
    out_status_q  <= out_status_d;
    out_len_q     <= out_len_d;
  end

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    is_ins_d      = is_ins_q;
    take_d        = take_q;
    upd_d         = upd_q;
    rd_pend_d     = 1'b0;
    ptr_d         = ptr_q;
    left_d        = left_q;
    rd_addr_d     = rd_addr_q;
    at_d          = at_q;
    val_d         = val_q;
    removed_d     = removed_q;
    status_d      = status_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_removed_d = out_removed_q;
    out_status_d  = out_status_q;
    out_len_d     = out_len_q;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = '0;
    mem_re        = 1'b0;
    mem_ra        = ptr_q;

    case (in_action)
      ACT_INS_TAIL: at_sel = cnt_ext;
      ACT_INS_POS:  at_sel = pos_ext;
      ACT_REM_TAIL: at_sel = cnt_ext - CMPW'(1);
      ACT_REM_POS:  at_sel = pos_ext;
      default:      at_sel = '0;
    endcase

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          removed_d = '0;
          status_d  = STAT_OK;
          upd_d     = 1'b0;
          take_d    = 1'b0;
          is_ins_d  = 1'b0;
          val_d     = VB'(in_value);
          at_d      = AW'(at_sel);
          left_d    = CW'(cnt_ext - at_sel);
          state_d   = ST_FINISH;
          case (in_action) inside
            ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_POS: begin
              if (at_sel > cnt_ext) begin
                status_d = STAT_BADPOS;
              end else if (count_q == CW'(DEPTH)) begin
                status_d = STAT_FULL;
              end else begin
                // shift from the tail down toward the insert point
                is_ins_d = 1'b1;
                ptr_d    = AW'(count_q - CW'(1));
                state_d  = ST_SHIFT;
              end
            end
            ACT_REM_HEAD, ACT_REM_TAIL, ACT_REM_POS: begin
              if (in_action != ACT_REM_POS && count_q == '0) begin
                status_d = STAT_EMPTY;
              end else if (at_sel >= cnt_ext) begin
                status_d = STAT_BADPOS;
              end else begin
                // first read returns the removed entry, the rest move down
                take_d  = 1'b1;
                ptr_d   = AW'(at_sel);
                state_d = ST_SHIFT;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SHIFT: begin
        if (left_q != '0) begin
          mem_re    = 1'b1;
          rd_pend_d = 1'b1;
          rd_addr_d = ptr_q;
          left_d    = left_q - CW'(1);
          ptr_d     = is_ins_q ? ptr_q - AW'(1) : ptr_q + AW'(1);
        end
        if (rd_pend_q) begin
          if (is_ins_q) begin
            mem_we = 1'b1;
            mem_wa = rd_addr_q + AW'(1);
            mem_wd = rd_data_q;
          end else if (take_q) begin
            removed_d = rd_data_q;
            take_d    = 1'b0;
          end else begin
            mem_we = 1'b1;
            mem_wa = rd_addr_q - AW'(1);
            mem_wd = rd_data_q;
          end
        end
        if (left_q == '0 && !rd_pend_q) begin
          if (is_ins_q) begin
            mem_we = 1'b1;
            mem_wa = at_q;
            mem_wd = val_q;
          end
          upd_d   = 1'b1;
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d   = 1'b1;
          out_removed_d = VAL_W'(removed_q);
          out_status_d  = status_q;
          out_len_d     = LEN_W'(count_next);
          count_d       = count_next;
          upd_d         = 1'b0;
          state_d       = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("list length beyond depth");

  a_rw_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_wa != mem_ra))
    else $error("shift reads and writes the same entry");

  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == STAT_EMPTY) |-> (out_len_q == '0))
    else $error("empty status with nonzero length");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q != ST_IDLE))
    else $error("accepted item not processed");

endmodule
